### hdl/pidpc_pkg.sv
// Shared types and constants for the PID position controller.
package pidpc_pkg;

  localparam int unsigned PC_W   = 4;
  localparam int unsigned IDX_W  = 3;
  localparam int unsigned CFG_W  = 16;

  typedef enum logic [2:0] {
    REG_PROP_GAIN  = 3'd0,
    REG_DERIV_GAIN = 3'd1,
    REG_INTEG_GAIN = 3'd2,
    REG_INT_ZONE   = 3'd3,
    REG_INT_LIMIT  = 3'd4,
    REG_OUT_SCALE  = 3'd5,
    REG_OUT_OFFSET = 3'd6
  } reg_idx_e;

  localparam logic [15:0]        RST_PROP_GAIN  = 16'd3584;
  localparam logic [15:0]        RST_DERIV_GAIN = 16'd15360;
  localparam logic [15:0]        RST_INTEG_GAIN = 16'd256;
  localparam logic [14:0]        RST_INT_ZONE   = 15'd100;
  localparam logic [14:0]        RST_INT_LIMIT  = 15'd2000;
  localparam logic signed [15:0] RST_OUT_SCALE  = -16'sd4951;
  localparam logic signed [7:0]  RST_OUT_OFFSET = 8'sd10;

  localparam logic signed [29:0] DRIVE_MAX = 30'sd127;
  localparam logic signed [29:0] DRIVE_MIN = -30'sd127;
  localparam logic [16:0]        SMALL_ERR = 17'd2;

  typedef enum logic [2:0] {
    DP_NONE,
    DP_LOAD_E,
    DP_DERIV,
    DP_CLAMP,
    DP_OUTPUT
  } dp_op_e;

  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_KP_E,
    MUL_KD_D,
    MUL_KI_I,
    MUL_T_SCALE
  } mul_sel_e;

  typedef enum logic [1:0] {
    ACC_NONE,
    ACC_LOAD,
    ACC_ADD
  } acc_op_e;

  typedef enum logic [1:0] {
    JMP_NEXT,
    JMP_WAIT_IN,
    JMP_WAIT_OUT
  } jmp_e;

  typedef struct packed {
    dp_op_e            dp;
    mul_sel_e          mul;
    acc_op_e           acc;
    jmp_e              jmp;
    logic [PC_W-1:0]   target;
  } uword_t;

  typedef struct packed {
    logic     fire;
    dp_op_e   dp;
    mul_sel_e mul;
    acc_op_e  acc;
  } dp_ctrl_t;

  typedef struct packed {
    logic [15:0]        prop_gain;
    logic [15:0]        deriv_gain;
    logic [15:0]        integ_gain;
    logic [14:0]        integral_zone;
    logic [14:0]        integral_limit;
    logic signed [15:0] output_scale;
    logic signed [7:0]  output_offset;
  } cfg_t;

endpackage

### hdl/pid_position_controller.sv
// Top level: PID position controller with integral zone, register file and stream ports.
// Each input transaction runs the 9-step microcode program on one shared 28x17 multiplier
// to a result in the output register; a new transaction is taken only after that, and a
// full output register stalls the last step.
// Reset: asynchronous active low; clears step counter, error history, integral,
// output valid and loads the register defaults.
module pid_position_controller (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // [15:0] measured_position, [31:16] target_position
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,   // [7:0] drive_power
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i
);

  pidpc_pkg::cfg_t     cfg_q;
  pidpc_pkg::dp_ctrl_t ctrl;
  logic                out_busy;
  logic signed [7:0]   drive_power;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.prop_gain      <= pidpc_pkg::RST_PROP_GAIN;
      cfg_q.deriv_gain     <= pidpc_pkg::RST_DERIV_GAIN;
      cfg_q.integ_gain     <= pidpc_pkg::RST_INTEG_GAIN;
      cfg_q.integral_zone  <= pidpc_pkg::RST_INT_ZONE;
      cfg_q.integral_limit <= pidpc_pkg::RST_INT_LIMIT;
      cfg_q.output_scale   <= pidpc_pkg::RST_OUT_SCALE;
      cfg_q.output_offset  <= pidpc_pkg::RST_OUT_OFFSET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        pidpc_pkg::REG_PROP_GAIN:  cfg_q.prop_gain      <= cfg_wdata_i;
        pidpc_pkg::REG_DERIV_GAIN: cfg_q.deriv_gain     <= cfg_wdata_i;
        pidpc_pkg::REG_INTEG_GAIN: cfg_q.integ_gain     <= cfg_wdata_i;
        pidpc_pkg::REG_INT_ZONE:   cfg_q.integral_zone  <= cfg_wdata_i[14:0];
        pidpc_pkg::REG_INT_LIMIT:  cfg_q.integral_limit <= cfg_wdata_i[14:0];
        pidpc_pkg::REG_OUT_SCALE:  cfg_q.output_scale   <= $signed(cfg_wdata_i);
        pidpc_pkg::REG_OUT_OFFSET: cfg_q.output_offset  <= $signed(cfg_wdata_i[7:0]);
        default: ;
      endcase
    end
  end

  pidpc_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .out_busy_i (out_busy),
    .in_ready_o (s_axis_tready_o),
    .ctrl_o     (ctrl)
  );

  pidpc_dp u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .ctrl_i              (ctrl),
    .cfg_i               (cfg_q),
    .measured_position_i ($signed(s_axis_tdata_i[15:0])),
    .target_position_i   ($signed(s_axis_tdata_i[31:16])),
    .out_ready_i         (m_axis_tready_i),
    .out_busy_o          (out_busy),
    .out_valid_o         (m_axis_tvalid_o),
    .drive_power_o       (drive_power)
  );

  assign m_axis_tdata_o = drive_power;

endmodule

### hdl/pidpc_seq.sv
// Microcode sequencer: step counter, control ROM and conditional jumps.
module pidpc_seq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                out_busy_i,
  output logic                in_ready_o,
  output pidpc_pkg::dp_ctrl_t ctrl_o
);

  logic [pidpc_pkg::PC_W-1:0] pc_q, pc_d;
  pidpc_pkg::uword_t          uw;
  logic                       stall;

  function automatic pidpc_pkg::uword_t rom(input logic [pidpc_pkg::PC_W-1:0] a);
    pidpc_pkg::uword_t w;
    w = '{pidpc_pkg::DP_NONE, pidpc_pkg::MUL_NONE, pidpc_pkg::ACC_NONE,
          pidpc_pkg::JMP_NEXT, 4'd0};
    unique case (a)
      4'd0: w = '{pidpc_pkg::DP_LOAD_E, pidpc_pkg::MUL_NONE, pidpc_pkg::ACC_NONE,
                  pidpc_pkg::JMP_WAIT_IN, 4'd0};
      4'd1: w = '{pidpc_pkg::DP_DERIV, pidpc_pkg::MUL_NONE, pidpc_pkg::ACC_NONE,
                  pidpc_pkg::JMP_NEXT, 4'd0};
      4'd2: w = '{pidpc_pkg::DP_CLAMP, pidpc_pkg::MUL_NONE, pidpc_pkg::ACC_NONE,
                  pidpc_pkg::JMP_NEXT, 4'd0};
      4'd3: w = '{pidpc_pkg::DP_NONE, pidpc_pkg::MUL_KP_E, pidpc_pkg::ACC_NONE,
                  pidpc_pkg::JMP_NEXT, 4'd0};
      4'd4: w = '{pidpc_pkg::DP_NONE, pidpc_pkg::MUL_KD_D, pidpc_pkg::ACC_LOAD,
                  pidpc_pkg::JMP_NEXT, 4'd0};
      4'd5: w = '{pidpc_pkg::DP_NONE, pidpc_pkg::MUL_KI_I, pidpc_pkg::ACC_ADD,
                  pidpc_pkg::JMP_NEXT, 4'd0};
      4'd6: w = '{pidpc_pkg::DP_NONE, pidpc_pkg::MUL_NONE, pidpc_pkg::ACC_ADD,
                  pidpc_pkg::JMP_NEXT, 4'd0};
      4'd7: w = '{pidpc_pkg::DP_NONE, pidpc_pkg::MUL_T_SCALE, pidpc_pkg::ACC_NONE,
                  pidpc_pkg::JMP_NEXT, 4'd0};
      4'd8: w = '{pidpc_pkg::DP_OUTPUT, pidpc_pkg::MUL_NONE, pidpc_pkg::ACC_NONE,
                  pidpc_pkg::JMP_WAIT_OUT, 4'd0};
      default: w = '{pidpc_pkg::DP_NONE, pidpc_pkg::MUL_NONE, pidpc_pkg::ACC_NONE,
                     pidpc_pkg::JMP_WAIT_OUT, 4'd0};
    endcase
    return w;
  endfunction

  always_comb begin
    uw         = rom(pc_q);
    in_ready_o = (uw.jmp == pidpc_pkg::JMP_WAIT_IN);
    stall      = ((uw.jmp == pidpc_pkg::JMP_WAIT_IN) && !in_valid_i) ||
                 ((uw.jmp == pidpc_pkg::JMP_WAIT_OUT) && out_busy_i);
    ctrl_o.fire = !stall;
    ctrl_o.dp   = uw.dp;
    ctrl_o.mul  = uw.mul;
    ctrl_o.acc  = uw.acc;
    pc_d = pc_q;
    if (!stall) begin
      unique case (uw.jmp)
        pidpc_pkg::JMP_WAIT_OUT: pc_d = uw.target;
        pidpc_pkg::JMP_NEXT,
        pidpc_pkg::JMP_WAIT_IN:  pc_d = pc_q + 4'd1;
        default:                 pc_d = uw.target;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= '0;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

### hdl/pidpc_dp.sv
// Datapath: error terms, integral clamp, shared multiplier, accumulator, output stage.
module pidpc_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pidpc_pkg::dp_ctrl_t ctrl_i,
  input  pidpc_pkg::cfg_t     cfg_i,
  input  logic signed [15:0]  measured_position_i,
  input  logic signed [15:0]  target_position_i,
  input  logic                out_ready_i,
  output logic                out_busy_o,
  output logic                out_valid_o,
  output logic signed [7:0]   drive_power_o
);

  logic signed [16:0] e_q, e_d, prev_q;
  logic signed [17:0] d_q, d_d;
  logic signed [17:0] integ_q, integ_d;
  logic signed [15:0] accum_q;
  logic signed [35:0] acc_q, acc_d;
  logic signed [44:0] mul_q;
  logic signed [27:0] mul_a;
  logic signed [16:0] mul_b;
  logic               out_valid_q;
  logic signed [7:0]  out_data_q, out_data_d;

  logic        [16:0] abs_e;
  logic               in_zone;
  logic signed [17:0] lim;
  logic signed [28:0] q_trunc;
  logic signed [29:0] q_sum;
  logic               load_out;

  always_comb begin
    abs_e   = e_q[16] ? (~e_q + 17'sd1) : e_q;
    in_zone = (abs_e < {2'b00, cfg_i.integral_zone}) && (abs_e > pidpc_pkg::SMALL_ERR);
    lim     = $signed({3'b000, cfg_i.integral_limit});

    e_d = $signed({target_position_i[15], target_position_i}) -
          $signed({measured_position_i[15], measured_position_i});

    d_d = (e_q == 17'sd0) ? 18'sd0 : ({e_q[16], e_q} - {prev_q[16], prev_q});

    integ_d = integ_q;
    if (ctrl_i.dp == pidpc_pkg::DP_DERIV) begin
      integ_d = in_zone ? ({{2{accum_q[15]}}, accum_q} + {e_q[16], e_q}) : 18'sd0;
    end else begin
      priority if (integ_q > lim) begin
        integ_d = lim;
      end else if (integ_q < -lim) begin
        integ_d = -lim;
      end else begin
        integ_d = integ_q;
      end
    end

    unique case (ctrl_i.mul)
      pidpc_pkg::MUL_KP_E: begin
        mul_a = {{11{e_q[16]}}, e_q};
        mul_b = $signed({1'b0, cfg_i.prop_gain});
      end
      pidpc_pkg::MUL_KD_D: begin
        mul_a = {{10{d_q[17]}}, d_q};
        mul_b = $signed({1'b0, cfg_i.deriv_gain});
      end
      pidpc_pkg::MUL_KI_I: begin
        mul_a = {{10{integ_q[17]}}, integ_q};
        mul_b = $signed({1'b0, cfg_i.integ_gain});
      end
      pidpc_pkg::MUL_T_SCALE: begin
        mul_a = acc_q[35:8];
        mul_b = {cfg_i.output_scale[15], cfg_i.output_scale};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase

    unique case (ctrl_i.acc)
      pidpc_pkg::ACC_LOAD: acc_d = mul_q[35:0];
      pidpc_pkg::ACC_ADD:  acc_d = acc_q + mul_q[35:0];
      default:             acc_d = acc_q;
    endcase

    // truncate toward zero: floor shift, then bump negatives with a remainder
    q_trunc = mul_q[44:16];
    if (mul_q[44] && (mul_q[15:0] != 16'd0)) begin
      q_trunc = q_trunc + 29'sd1;
    end
    q_sum = {q_trunc[28], q_trunc} +
            {{22{cfg_i.output_offset[7]}}, cfg_i.output_offset};
    priority if (q_sum > pidpc_pkg::DRIVE_MAX) begin
      out_data_d = 8'sd127;
    end else if (q_sum < pidpc_pkg::DRIVE_MIN) begin
      out_data_d = -8'sd127;
    end else begin
      out_data_d = q_sum[7:0];
    end

    load_out   = ctrl_i.fire && (ctrl_i.dp == pidpc_pkg::DP_OUTPUT);
    out_busy_o = out_valid_q && !out_ready_i;
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.fire) begin
      if (ctrl_i.dp == pidpc_pkg::DP_LOAD_E) begin
        e_q <= e_d;
      end
      if (ctrl_i.dp == pidpc_pkg::DP_DERIV) begin
        d_q <= d_d;
      end
      if ((ctrl_i.dp == pidpc_pkg::DP_DERIV) || (ctrl_i.dp == pidpc_pkg::DP_CLAMP)) begin
        integ_q <= integ_d;
      end
      if (ctrl_i.mul != pidpc_pkg::MUL_NONE) begin
        mul_q <= mul_a * mul_b;
      end
      acc_q <= acc_d;
    end
    if (load_out) begin
      out_data_q <= out_data_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q      <= '0;
      accum_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (ctrl_i.fire && (ctrl_i.dp == pidpc_pkg::DP_CLAMP)) begin
        prev_q  <= e_q;
        accum_q <= integ_d[15:0];
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign drive_power_o = out_data_q;

endmodule

### hdl/pidpc_chk.sv
// Port-level checker for the PID position controller, bound to the top level.
module pidpc_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [7:0]  m_axis_tdata_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("output changed while stalled");

  a_no_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o != 8'h80)
    else $error("drive_power outside saturation range");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("second transaction taken while busy");

  a_no_early_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> !$past(s_axis_tvalid_i && s_axis_tready_o))
    else $error("result appeared one cycle after input");

endmodule

bind pid_position_controller pidpc_chk u_chk (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);
